[rtl/vcpu_affinity_balancer_core_assert.svh]
// Assertion macros used by the balancer datapath.
`ifndef VCPU_AFFINITY_BALANCER_CORE_ASSERT_SVH
`define VCPU_AFFINITY_BALANCER_CORE_ASSERT_SVH

// Same-cycle implication.
`define VAB_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define VAB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/vab_pkg.sv]
package vab_pkg;

	localparam int DELTA_W       = 48;
	localparam int CPU_FIELD_W   = 4;
	localparam int INDEX_FIELD_W = 5;
	localparam int CFG_W         = 5;
	localparam int QUIET_W       = 4;
	localparam int QUIET_LIMIT   = 6;
	localparam int SCORE_FORCE   = 5;
	localparam logic [CFG_W-1:0] NUM_CPUS_RST = 5'd4;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CLR,
		ST_TALLY,
		ST_SCORE,
		ST_DECIDE,
		ST_PCLR,
		ST_PICK,
		ST_FIND,
		ST_PLACE,
		ST_CHECK,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_CLR,
		OP_TALLY,
		OP_SCORE,
		OP_DECIDE,
		OP_PCLR,
		OP_PICK,
		OP_FIND,
		OP_PLACE,
		OP_CHECK,
		OP_EMIT_RD,
		OP_EMIT_OUT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic score_stop;
		logic recalc;
		logic place_done;
		logic pos_open;
		logic emit_last;
		logic out_free;
	} status_t;

endpackage

[rtl/vab_in_if.sv]
interface vab_in_if;
	import vab_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [DELTA_W-1:0]     cpu_time_delta;
	logic [CPU_FIELD_W-1:0] current_cpu;
	logic                   last;

	modport source (output valid, cpu_time_delta, current_cpu, last, input ready);
	modport sink (input valid, cpu_time_delta, current_cpu, last, output ready);
endinterface

[rtl/vab_out_if.sv]
interface vab_out_if;
	import vab_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [INDEX_FIELD_W-1:0] domain_index;
	logic [CPU_FIELD_W-1:0]   new_cpu;
	logic                     pin_needed;
	logic                     recalculated;
	logic                     end_of_round;

	modport source (output valid, domain_index, new_cpu, pin_needed, recalculated,
		end_of_round, input ready);
	modport sink (input valid, domain_index, new_cpu, pin_needed, recalculated,
		end_of_round, output ready);
endinterface

[rtl/vab_ctrl.sv]
module vab_ctrl
	import vab_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_last,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd.op   = OP_IDLE;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					if (in_last) state_d = ST_CLR;
				end
			end
			ST_CLR: begin
				cmd.op  = OP_CLR;
				state_d = ST_TALLY;
			end
			ST_TALLY: begin
				cmd.op = OP_TALLY;
				if (st.scan_done) state_d = ST_SCORE;
			end
			ST_SCORE: begin
				cmd.op = OP_SCORE;
				if (st.score_stop) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.op  = OP_DECIDE;
				state_d = st.recalc ? ST_PCLR : ST_EMIT_RD;
			end
			ST_PCLR: begin
				cmd.op  = OP_PCLR;
				state_d = ST_PICK;
			end
			ST_PICK: begin
				cmd.op = OP_PICK;
				if (st.place_done) state_d = ST_EMIT_RD;
				else if (st.pos_open) state_d = ST_FIND;
			end
			ST_FIND: begin
				cmd.op = OP_FIND;
				if (st.scan_done) state_d = ST_PLACE;
			end
			ST_PLACE: begin
				cmd.op  = OP_PLACE;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.op  = OP_CHECK;
				state_d = ST_PICK;
			end
			ST_EMIT_RD: begin
				cmd.op  = OP_EMIT_RD;
				state_d = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				cmd.op = OP_EMIT_OUT;
				if (st.out_free) state_d = st.emit_last ? ST_LOAD : ST_EMIT_RD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

endmodule

[rtl/vab_dp.sv]
`include "vcpu_affinity_balancer_core_assert.svh"

module vab_dp
	import vab_pkg::*;
#(
	parameter int MAX_DOMAINS = 32,
	parameter int MAX_CPUS    = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	output status_t                    st,
	input  logic                       cfg_we,
	input  logic [CFG_W-1:0]           cfg_wdata,
	input  logic [DELTA_W-1:0]         in_delta,
	input  logic [CPU_FIELD_W-1:0]     in_cpu,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [INDEX_FIELD_W-1:0]   out_index,
	output logic [CPU_FIELD_W-1:0]     out_new_cpu,
	output logic                       out_pin,
	output logic                       out_recalc,
	output logic                       out_end
);

	localparam int AW    = (MAX_DOMAINS > 1) ? $clog2(MAX_DOMAINS) : 1;
	localparam int CW    = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
	localparam int CNT_W = $clog2(MAX_DOMAINS + 1);
	localparam int NW    = $clog2(MAX_CPUS + 1);
	localparam int SUM_W = DELTA_W + AW;
	localparam int PW    = SUM_W + NW;
	localparam int SC_W  = NW + 4;

	// storage
	logic [DELTA_W-1:0]     delta_mem [MAX_DOMAINS];
	logic [CPU_FIELD_W-1:0] cpu_mem   [MAX_DOMAINS];
	logic [CW-1:0]          ncpu_mem  [MAX_DOMAINS];

	logic [CFG_W-1:0]       ncfg_q;
	logic [CNT_W-1:0]       count_q, j_q, placed_cnt_q;
	logic [SUM_W-1:0]       total_q;
	logic [SUM_W-1:0]       load_q [MAX_CPUS];
	logic [1:0]             cnt_q  [MAX_CPUS];
	logic [MAX_CPUS-1:0]    open_q;
	logic [MAX_DOMAINS-1:0] placed_q;
	logic [CW-1:0]          pos_q;
	logic                   dir_q;
	logic signed [SC_W-1:0] score_q;
	logic [QUIET_W-1:0]     quiet_q;
	logic                   recalc_q;
	logic                   vld_s1;
	logic [AW-1:0]          idx_s1;
	logic [DELTA_W-1:0]     rdelta_s1;
	logic [CPU_FIELD_W-1:0] rcpu_s1;
	logic [CW-1:0]          rncpu_s1;
	logic                   best_v_q;
	logic [DELTA_W-1:0]     best_delta_q;
	logic [AW-1:0]          best_idx_q;

	logic [NW-1:0]          n_eff;
	logic                   load_we, scan_issue, rd_en, any_open, last_pos, over, cand;
	logic [PW-1:0]          prod;
	logic [CW-1:0]          pos_adv;
	logic                   dir_adv;
	logic [CPU_FIELD_W-1:0] nc;

	always_comb begin
		if (ncfg_q == '0) n_eff = NW'(1);
		else if (32'(ncfg_q) > MAX_CPUS) n_eff = NW'(MAX_CPUS);
		else n_eff = NW'(ncfg_q);
	end

	assign load_we    = (cmd.op == OP_LOAD) && (32'(count_q) < MAX_DOMAINS);
	assign scan_issue = ((cmd.op == OP_TALLY) || (cmd.op == OP_FIND)) && (j_q < count_q);
	assign rd_en      = scan_issue || (cmd.op == OP_EMIT_RD);
	assign last_pos   = (32'(pos_q) == 32'(n_eff) - 1);
	assign prod       = PW'(load_q[pos_q]) * PW'(n_eff);
	assign over       = prod > PW'(total_q);
	assign cand       = vld_s1 && !placed_q[idx_s1] && (!best_v_q || rdelta_s1 > best_delta_q);

	always_comb begin
		any_open = 1'b0;
		for (int c = 0; c < MAX_CPUS; c++) begin
			if (c < 32'(n_eff) && open_q[c]) any_open = 1'b1;
		end
	end

	// snake walk: up to n-1, then back down to 0, end CPUs visited twice
	always_comb begin
		pos_adv = pos_q;
		dir_adv = dir_q;
		if (!dir_q) begin
			if (last_pos) dir_adv = 1'b1;
			else pos_adv = pos_q + CW'(1);
		end else begin
			if (pos_q == '0) dir_adv = 1'b0;
			else pos_adv = pos_q - CW'(1);
		end
	end

	assign st.scan_done  = (j_q == count_q) && !vld_s1;
	assign st.score_stop = (over && cnt_q[pos_q][1]) || last_pos;
	assign st.recalc     = !score_q[SC_W-1] || (quiet_q > QUIET_W'(QUIET_LIMIT));
	assign st.place_done = (placed_cnt_q == count_q) || !any_open;
	assign st.pos_open   = open_q[pos_q];
	assign st.emit_last  = (j_q + CNT_W'(1)) == count_q;
	assign st.out_free   = !out_valid || out_ready;

	assign nc = (recalc_q && placed_q[idx_s1]) ? CPU_FIELD_W'(rncpu_s1) : rcpu_s1;

	always_ff @(posedge clk) begin
		if (load_we) begin
			delta_mem[count_q[AW-1:0]] <= in_delta;
			cpu_mem[count_q[AW-1:0]]   <= in_cpu;
		end
		if (cmd.op == OP_PLACE) ncpu_mem[best_idx_q] <= pos_q;
		if (rd_en) begin
			rdelta_s1 <= delta_mem[j_q[AW-1:0]];
			rcpu_s1   <= cpu_mem[j_q[AW-1:0]];
			rncpu_s1  <= ncpu_mem[j_q[AW-1:0]];
			idx_s1    <= j_q[AW-1:0];
		end
		if (cmd.op == OP_EMIT_OUT && st.out_free) begin
			out_index   <= INDEX_FIELD_W'(j_q);
			out_new_cpu <= nc;
			out_pin     <= nc != rcpu_s1;
			out_recalc  <= recalc_q;
			out_end     <= st.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncfg_q       <= NUM_CPUS_RST;
			count_q      <= '0;
			j_q          <= '0;
			placed_cnt_q <= '0;
			total_q      <= '0;
			for (int c = 0; c < MAX_CPUS; c++) begin
				load_q[c] <= '0;
				cnt_q[c]  <= '0;
			end
			open_q       <= '1;
			placed_q     <= '0;
			pos_q        <= '0;
			dir_q        <= 1'b0;
			score_q      <= '0;
			quiet_q      <= '0;
			recalc_q     <= 1'b0;
			vld_s1       <= 1'b0;
			best_v_q     <= 1'b0;
			best_delta_q <= '0;
			best_idx_q   <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_we) ncfg_q <= cfg_wdata;
			vld_s1 <= scan_issue;
			if (scan_issue) j_q <= j_q + CNT_W'(1);
			if (cmd.op == OP_EMIT_OUT && st.out_free) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;

			unique case (cmd.op)
				OP_LOAD: begin
					if (load_we) begin
						count_q <= count_q + CNT_W'(1);
						total_q <= total_q + SUM_W'(in_delta);
					end
				end
				OP_CLR: begin
					for (int c = 0; c < MAX_CPUS; c++) begin
						load_q[c] <= '0;
						cnt_q[c]  <= '0;
					end
					open_q  <= '1;
					j_q     <= '0;
					pos_q   <= '0;
					score_q <= '0;
				end
				OP_TALLY: begin
					if (vld_s1 && 32'(rcpu_s1) < 32'(n_eff)) begin
						load_q[CW'(rcpu_s1)] <= load_q[CW'(rcpu_s1)] + SUM_W'(rdelta_s1);
						if (!cnt_q[CW'(rcpu_s1)][1])
							cnt_q[CW'(rcpu_s1)] <= cnt_q[CW'(rcpu_s1)] + 2'd1;
					end
				end
				OP_SCORE: begin
					if (over && cnt_q[pos_q][1]) score_q <= SC_W'(SCORE_FORCE);
					else if (!over && cnt_q[pos_q] != 2'd2) score_q <= score_q + SC_W'(1);
					else score_q <= score_q - SC_W'(1);
					pos_q <= pos_q + CW'(1);
				end
				OP_DECIDE: begin
					recalc_q <= st.recalc;
					quiet_q  <= st.recalc ? '0 : quiet_q + QUIET_W'(1);
					j_q      <= '0;
				end
				OP_PCLR: begin
					for (int c = 0; c < MAX_CPUS; c++) load_q[c] <= '0;
					open_q       <= '1;
					placed_q     <= '0;
					placed_cnt_q <= '0;
					pos_q        <= '0;
					dir_q        <= 1'b0;
				end
				OP_PICK: begin
					j_q      <= '0;
					best_v_q <= 1'b0;
					if (!st.place_done && !open_q[pos_q]) begin
						pos_q <= pos_adv;
						dir_q <= dir_adv;
					end
				end
				OP_FIND: begin
					if (cand) begin
						best_v_q     <= 1'b1;
						best_delta_q <= rdelta_s1;
						best_idx_q   <= idx_s1;
					end
				end
				OP_PLACE: begin
					load_q[pos_q]        <= load_q[pos_q] + SUM_W'(best_delta_q);
					placed_q[best_idx_q] <= 1'b1;
					placed_cnt_q         <= placed_cnt_q + CNT_W'(1);
				end
				OP_CHECK: begin
					if (over) open_q[pos_q] <= 1'b0;
					pos_q <= pos_adv;
					dir_q <= dir_adv;
					j_q   <= '0;
				end
				OP_EMIT_OUT: begin
					if (st.out_free) begin
						j_q <= j_q + CNT_W'(1);
						if (st.emit_last) begin
							count_q      <= '0;
							total_q      <= '0;
							placed_cnt_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	`VAB_ASSERT(a_placed_le_count, clk, arst_n, 1'b1, placed_cnt_q <= count_q, "placed count above domain count")
	`VAB_ASSERT(a_place_on_open, clk, arst_n, cmd.op == OP_PLACE, open_q[pos_q], "placement on a closed CPU")
	`VAB_ASSERT_NEXT(a_round_end_clears, clk, arst_n, cmd.op == OP_EMIT_OUT && st.out_free && st.emit_last, count_q == '0 && total_q == '0 && out_valid, "round state not cleared")

endmodule

[rtl/vcpu_affinity_balancer_core.sv]
// Channel  | Dir | Payload                                              | Transfer
// item     | in  | cpu_time_delta, current_cpu, last                    | valid & ready
// result   | out | domain_index, new_cpu, pin_needed, recalculated, eor | valid & ready
// num_cpus | in  | num_cpus_wdata (5b)                                  | num_cpus_we
//
// Cycles: one per item transfer while loading. The item with last set then runs
// the load tally over d domains, scoring of up to n CPUs and, on a recalc, per
// placed domain a one-port scan of the domain store for the largest unplaced
// delta, the add and the close test, skipping closed CPUs; then emits each result.
// Reset: async, active low; round counters, CPU tables and quiet count clear.
// Stalls: result backpressure holds the emit phase; the next round's items are
// taken while the final result transfer is still pending.
module vcpu_affinity_balancer_core
	import vab_pkg::*;
#(
	parameter int MAX_DOMAINS = 32,
	parameter int MAX_CPUS    = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	vab_in_if.sink           item,
	vab_out_if.source        result,
	input  logic             num_cpus_we,
	input  logic [CFG_W-1:0] num_cpus_wdata
);

	cmd_t    cmd;
	status_t st;

	// sequencer: walks load, tally, score, placement and emit phases
	vab_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_last  (item.last),
		.in_ready (item.ready),
		.st       (st),
		.cmd      (cmd)
	);

	// stores, CPU tables, share compare and result register
	vab_dp #(
		.MAX_DOMAINS (MAX_DOMAINS),
		.MAX_CPUS    (MAX_CPUS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.cfg_we      (num_cpus_we),
		.cfg_wdata   (num_cpus_wdata),
		.in_delta    (item.cpu_time_delta),
		.in_cpu      (item.current_cpu),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.out_index   (result.domain_index),
		.out_new_cpu (result.new_cpu),
		.out_pin     (result.pin_needed),
		.out_recalc  (result.recalculated),
		.out_end     (result.end_of_round)
	);

endmodule
